[rtl/core/dpfr_pkg.sv]
// Package for the demand page fault resolver: payload structs, table entry
// layout and page constants. No dependencies; imported by demand_page_fault_resolver_unit.

package dpfr_pkg;

	localparam int unsigned PAGE_BYTES = 4096;
	localparam int unsigned PAGE_SHIFT = 12;

	// Input transaction: table write or fault lookup
	typedef struct packed {
		logic        operation;
		logic [3:0]  entry_index;
		logic        entry_is_load;
		logic [31:0] entry_vaddr;
		logic [31:0] entry_mem_size;
		logic [31:0] entry_file_offset;
		logic [31:0] entry_file_size;
		logic [31:0] fault_address;
	} in_item_t;

	// Output transaction: one per input transaction
	typedef struct packed {
		logic        hit;
		logic [3:0]  segment_index;
		logic [31:0] page_addr;
		logic [31:0] file_offset;
		logic [12:0] copy_length;
		logic [11:0] frag_added;
		logic [31:0] fault_total;
		logic [47:0] frag_total;
	} out_item_t;

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_FAULT = 1'b1;

	// Segment table word; the end address is formed once when the entry is written
	typedef struct packed {
		logic        loadable;
		logic [31:0] base_addr;
		logic [31:0] seg_end;
		logic [31:0] file_start;
		logic [31:0] file_size;
	} seg_entry_t;

endpackage

[rtl/core/dpfr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module dpfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/core/demand_page_fault_resolver_unit.sv]
// Top level of the demand page fault resolver: segment table walk and page
// resolve over one shared 32-bit add/subtract unit. Uses dpfr_pkg, dpfr_ram.
//
//  channel  | signals                    | direction | payload
//  ---------+----------------------------+-----------+------------------------
//  input    | in_valid, in_stall         | in        | in_item  (in_item_t)
//  output   | out_valid, out_stall       | out       | out_item (out_item_t)
//  config   | cfg_wr_en, cfg_wr_data     | in        | segment_count, 5 bits
//
// A table write returns its result the cycle after acceptance.
// A fault walks the table with one RAM read per entry and the compare of each entry
// in the cycle after its read. On a hit the shared adder steps through S_OFF,
// S_FOFF, S_REM, S_PEND and S_TAIL, and S_DONE commits the result once the output
// register is free. A miss goes to S_DONE after the last entry is compared, or at
// once when nothing is searched. A new transaction is taken at the earliest
// at the edge where the previous result is taken.
// Reset clears the sequencer, counters and segment_count; the table is undefined.
// The input stalls while a fault is in work, or while a result waits on a stalled output.

module demand_page_fault_resolver_unit #(
	parameter int unsigned MAX_SEGMENTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dpfr_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output dpfr_pkg::out_item_t out_item,
	input  logic                cfg_wr_en,
	input  logic [4:0]          cfg_wr_data
);

	import dpfr_pkg::*;

	localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned EW = $bits(seg_entry_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_OFF,
		S_FOFF,
		S_REM,
		S_PEND,
		S_TAIL,
		S_DONE
	} state_t;

	state_t      state_q;
	logic [4:0]  segment_count_q;
	logic [31:0] fault_cnt_q;
	logic [47:0] frag_q;
	out_item_t   out_q;
	logic        out_valid_q;
	logic        found_q;
	logic [CW-1:0] limit_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] chk_idx_q;
	logic        chk_vld_q;

	// Datapath registers
	logic [31:0] addr_q;
	seg_entry_t  seg_q;
	logic [3:0]  hit_idx_q;
	logic [31:0] off_q;
	logic [31:0] foff_q;
	logic [31:0] rem_q;
	logic        infile_q;
	logic [31:0] pend_q;
	logic [11:0] fadd_q;

	logic        in_acc;
	logic        out_free;
	logic        out_load;
	out_item_t   out_nxt;
	logic [CW-1:0] limit_nxt;
	logic        tbl_wr;
	seg_entry_t  wr_entry;
	logic        rd_en;
	logic [EW-1:0] rd_word;
	seg_entry_t  rd_entry;
	logic        match;
	logic        chk_last;
	logic [31:0] pstart;
	logic [31:0] alu_a;
	logic [31:0] alu_b;
	logic        alu_sub;
	logic [32:0] alu_res;
	logic [12:0] clen;
	logic [31:0] cnt_nxt;
	logic [48:0] frag_sum;
	logic [47:0] frag_nxt;

	// Handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Clamp the walk length to the table depth
	always_comb begin
		if (32'(segment_count_q) > 32'(MAX_SEGMENTS)) begin
			limit_nxt = CW'(MAX_SEGMENTS);
		end else begin
			limit_nxt = CW'(segment_count_q);
		end
	end

	// Table write; entries beyond the table are dropped
	assign tbl_wr = in_acc && (in_item.operation == OP_WRITE)
		&& (32'(in_item.entry_index) < 32'(MAX_SEGMENTS));
	always_comb begin
		wr_entry.loadable   = in_item.entry_is_load;
		wr_entry.base_addr  = in_item.entry_vaddr;
		wr_entry.seg_end    = in_item.entry_vaddr + in_item.entry_mem_size;
		wr_entry.file_start = in_item.entry_file_offset;
		wr_entry.file_size  = in_item.entry_file_size;
	end

	assign rd_en = (state_q == S_SCAN) && (rd_idx_q < limit_q);

	dpfr_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_SEGMENTS)
	) u_seg_ram (
		.clk     (clk),
		.wr_en   (tbl_wr),
		.wr_addr (IW'(in_item.entry_index)),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (IW'(rd_idx_q)),
		.rd_data (rd_word)
	);

	// Range check on the entry read last cycle
	assign rd_entry = seg_entry_t'(rd_word);
	assign match    = rd_entry.loadable && (addr_q >= rd_entry.base_addr)
		&& (addr_q < rd_entry.seg_end);
	assign chk_last = ((chk_idx_q + CW'(1)) == limit_q);

	assign pstart = addr_q & ~(32'(PAGE_BYTES) - 32'd1);

	// Shared adder operand select
	always_comb begin
		unique case (state_q)
			S_OFF: begin
				alu_a = pstart; alu_b = seg_q.base_addr; alu_sub = 1'b1;
			end
			S_FOFF: begin
				alu_a = seg_q.file_start; alu_b = off_q; alu_sub = 1'b0;
			end
			S_REM: begin
				alu_a = seg_q.file_size; alu_b = off_q; alu_sub = 1'b1;
			end
			S_PEND: begin
				alu_a = pstart; alu_b = 32'(PAGE_BYTES); alu_sub = 1'b0;
			end
			S_TAIL: begin
				alu_a = pend_q; alu_b = seg_q.seg_end; alu_sub = 1'b1;
			end
			default: begin
				alu_a = '0; alu_b = '0; alu_sub = 1'b0;
			end
		endcase
	end
	// Carry out of a subtract is set when a >= b
	assign alu_res = {1'b0, alu_a} + {1'b0, alu_b ^ {32{alu_sub}}} + 33'(alu_sub);

	// Copy length: remaining file bytes capped at one page
	always_comb begin
		if (!infile_q) begin
			clen = '0;
		end else if (rem_q[31:PAGE_SHIFT] == '0) begin
			clen = 13'(rem_q);
		end else begin
			clen = 13'(PAGE_BYTES);
		end
	end

	// Saturating counter updates
	assign cnt_nxt  = (fault_cnt_q == '1) ? fault_cnt_q : fault_cnt_q + 32'd1;
	assign frag_sum = {1'b0, frag_q} + 49'(fadd_q);
	assign frag_nxt = frag_sum[48] ? '1 : frag_sum[47:0];

	// Next output transaction: counters only, or the full resolution on a hit
	always_comb begin
		out_nxt             = '0;
		out_nxt.fault_total = fault_cnt_q;
		out_nxt.frag_total  = frag_q;
		if ((state_q == S_DONE) && found_q) begin
			out_nxt.hit           = 1'b1;
			out_nxt.segment_index = hit_idx_q;
			out_nxt.page_addr     = pstart;
			out_nxt.file_offset   = foff_q;
			out_nxt.copy_length   = clen;
			out_nxt.frag_added    = fadd_q;
			out_nxt.fault_total   = cnt_nxt;
			out_nxt.frag_total    = frag_nxt;
		end
	end
	assign out_load = (in_acc && (in_item.operation == OP_WRITE))
		|| ((state_q == S_DONE) && out_free);

	// Sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			segment_count_q <= '0;
			fault_cnt_q     <= '0;
			frag_q          <= '0;
			out_q           <= '0;
			out_valid_q     <= 1'b0;
			found_q         <= 1'b0;
			limit_q         <= '0;
			rd_idx_q        <= '0;
			chk_idx_q       <= '0;
			chk_vld_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				segment_count_q <= cfg_wr_data;
			end
			// Load a new output transaction, or drop the current one once taken
			if (out_load) begin
				out_q       <= out_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (in_item.operation == OP_FAULT)) begin
						limit_q   <= limit_nxt;
						rd_idx_q  <= '0;
						chk_vld_q <= 1'b0;
						found_q   <= 1'b0;
						state_q   <= (limit_nxt == '0) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					// Advance the read pointer; the compare runs in the cycle after the read
					if (rd_en) begin
						rd_idx_q  <= rd_idx_q + CW'(1);
						chk_idx_q <= rd_idx_q;
					end
					chk_vld_q <= rd_en;
					if (chk_vld_q) begin
						if (match) begin
							found_q <= 1'b1;
							state_q <= S_OFF;
						end else if (chk_last) begin
							state_q <= S_DONE;
						end
					end
				end
				S_OFF:  state_q <= S_FOFF;
				S_FOFF: state_q <= S_REM;
				S_REM:  state_q <= S_PEND;
				S_PEND: state_q <= S_TAIL;
				S_TAIL: state_q <= S_DONE;
				S_DONE: begin
					// Commit once the output register is free
					if (out_free) begin
						state_q <= S_IDLE;
						if (found_q) begin
							fault_cnt_q <= cnt_nxt;
							frag_q      <= frag_nxt;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers, loaded step by step
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q <= in_item.fault_address;
		end
		if ((state_q == S_SCAN) && chk_vld_q && match) begin
			seg_q     <= rd_entry;
			hit_idx_q <= 4'(chk_idx_q);
		end
		unique case (state_q)
			S_OFF:  off_q  <= alu_res[31:0];
			S_FOFF: foff_q <= alu_res[31:0];
			S_REM: begin
				rem_q    <= alu_res[31:0];
				infile_q <= alu_res[32] && (alu_res[31:0] != '0);
			end
			S_PEND: pend_q <= alu_res[31:0];
			S_TAIL: begin
				// Tail beyond the segment end counts only when file bytes lie on the page
				if (infile_q && alu_res[32] && (alu_res[31:0] != '0)) begin
					fadd_q <= alu_res[PAGE_SHIFT-1:0];
				end else begin
					fadd_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
